>>> hdl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, codes and constants of the tone beep sequencer.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Width of the PWM source clock frequency register.
  localparam int CLK_W     = 28;
  // Width of the trial divisor (divider times tone frequency).
  localparam int DIVISOR_W = 18;
  localparam int FREQ_W    = 10;
  localparam int DIV_W     = 8;
  localparam int WRAP_W    = 16;
  localparam int LEVEL_W   = 15;
  localparam int MS_W      = 10;

  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 28'd125000000;

  // Tone set-up limits.
  localparam logic [WRAP_W-1:0] WRAP_MAX   = 16'd65535;
  localparam logic [WRAP_W-1:0] WRAP_MIN   = 16'd10;
  localparam logic [WRAP_W-1:0] WRAP_RESET = 16'd1000;
  localparam logic [DIV_W-1:0]  DIV_MAX    = 8'd255;
  localparam logic [DIV_W-1:0]  DIV_RESET  = 8'd1;
  // A quotient above this gives a wrap that does not fit in 16 bits.
  localparam logic [CLK_W-1:0]  QUOT_LIMIT = 28'd65536;

  // Operation codes of the input item.
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_GAMEPLAY = 3'd2;
  localparam logic [2:0] OP_MENU     = 3'd3;
  localparam logic [2:0] OP_GAMEOVER = 3'd4;
  localparam logic [2:0] OP_STOP     = 3'd5;

  // Sound mode codes of the result item.
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_MENU     = 3'd1;
  localparam logic [2:0] MODE_START    = 3'd2;
  localparam logic [2:0] MODE_GAMEPLAY = 3'd3;
  localparam logic [2:0] MODE_GAMEOVER = 3'd4;

  // Tones that the sequencer can ask for.
  typedef enum logic [1:0] {
    FQ_880,
    FQ_440,
    FQ_220,
    FQ_180
  } freq_sel_t;

  function automatic logic [FREQ_W-1:0] tone_freq(input freq_sel_t sel);
    logic [FREQ_W-1:0] f;
    case (sel)
      FQ_880:  f = 10'd880;
      FQ_440:  f = 10'd440;
      FQ_220:  f = 10'd220;
      FQ_180:  f = 10'd180;
      default: f = 10'd440;
    endcase
    return f;
  endfunction

  // Command from the controller to the datapath.
  typedef struct packed {
    logic      set_tone;
    logic      silence;
    freq_sel_t freq;
  } tbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_W-1:0]   divider;
    logic [WRAP_W-1:0]  wrap;
    logic [LEVEL_W-1:0] level;
  } tbs_status_t;

endpackage

>>> hdl/tbs_in_if.sv
// ----------------------------------------------------------------------------
// tbs_in_if
// Input channel of the tone beep sequencer: one tick or command per transfer.
// ----------------------------------------------------------------------------
interface tbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       active;

  modport source (output valid, output op, output active, input ready);
  modport sink   (input valid, input op, input active, output ready);
endinterface

>>> hdl/tbs_out_if.sv
// ----------------------------------------------------------------------------
// tbs_out_if
// Result channel of the tone beep sequencer: sound state and PWM settings.
// ----------------------------------------------------------------------------
interface tbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   play_mode;
  logic                         tone_on;
  logic [tbs_pkg::DIV_W-1:0]    clock_divider;
  logic [tbs_pkg::WRAP_W-1:0]   pwm_wrap;
  logic [tbs_pkg::LEVEL_W-1:0]  pwm_level;

  modport source (output valid, output play_mode, output tone_on, output clock_divider,
                  output pwm_wrap, output pwm_level, input ready);
  modport sink   (input valid, input play_mode, input tone_on, input clock_divider,
                  input pwm_wrap, input pwm_level, output ready);
endinterface

>>> hdl/tbs_dp.sv
// ----------------------------------------------------------------------------
// tbs_dp
// Tone datapath: clock frequency register, divider search with a bit-serial
// divider, and the divider, wrap and level registers of the PWM tone.
// ----------------------------------------------------------------------------
module tbs_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tbs_pkg::CLK_W-1:0]  cfg_wr_data,
  input  tbs_pkg::tbs_cmd_t          cmd,
  output tbs_pkg::tbs_status_t       status
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_DIV,
    D_CHECK
  } dstate_t;

  localparam int STEP_W = $clog2(tbs_pkg::CLK_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(tbs_pkg::CLK_W - 1);

  dstate_t                            state_r;
  logic [tbs_pkg::CLK_W-1:0]          clk_hz_r;
  logic [tbs_pkg::FREQ_W-1:0]         freq_r;
  logic [tbs_pkg::DIV_W-1:0]          div_try_r;
  logic [tbs_pkg::DIVISOR_W-1:0]      divisor_r;
  logic [tbs_pkg::CLK_W-1:0]          quot_r;
  logic [tbs_pkg::DIVISOR_W-1:0]      rem_r;
  logic [STEP_W-1:0]                  step_r;
  logic [tbs_pkg::DIV_W-1:0]          divider_r;
  logic [tbs_pkg::WRAP_W-1:0]         wrap_r;
  logic [tbs_pkg::LEVEL_W-1:0]        level_r;
  logic                               done_r;

  logic [tbs_pkg::DIVISOR_W:0]        trial;
  logic [tbs_pkg::DIVISOR_W:0]        diff;
  logic                               fits;
  logic [tbs_pkg::DIVISOR_W-1:0]      rem_nxt;
  logic [tbs_pkg::CLK_W-1:0]          quot_nxt;
  logic                               too_big;
  logic [tbs_pkg::WRAP_W:0]           quot_m1;
  logic [tbs_pkg::WRAP_W-1:0]         wrap_nxt;

  // One restoring division step: bring in the next dividend bit and subtract.
  always_comb begin
    trial    = {rem_r, quot_r[tbs_pkg::CLK_W-1]};
    diff     = trial - {1'b0, divisor_r};
    fits     = (trial >= {1'b0, divisor_r});
    rem_nxt  = fits ? diff[tbs_pkg::DIVISOR_W-1:0] : trial[tbs_pkg::DIVISOR_W-1:0];
    quot_nxt = {quot_r[tbs_pkg::CLK_W-2:0], fits};
  end

  // Check of the finished quotient. A zero quotient makes wrap underflow,
  // so it counts as too large just as a quotient above the limit does.
  always_comb begin
    too_big  = (quot_r == '0) || (quot_r > tbs_pkg::QUOT_LIMIT);
    quot_m1  = quot_r[tbs_pkg::WRAP_W:0] - 17'd1;
    if (too_big) begin
      wrap_nxt = tbs_pkg::WRAP_MAX;
    end else if (quot_m1[tbs_pkg::WRAP_W-1:0] < tbs_pkg::WRAP_MIN) begin
      wrap_nxt = tbs_pkg::WRAP_MIN;
    end else begin
      wrap_nxt = quot_m1[tbs_pkg::WRAP_W-1:0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= tbs_pkg::CLK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // Divider search sequencing and tone registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= D_IDLE;
      done_r    <= 1'b0;
      divider_r <= tbs_pkg::DIV_RESET;
      wrap_r    <= tbs_pkg::WRAP_RESET;
      level_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (cmd.set_tone) begin
            freq_r    <= tbs_pkg::tone_freq(cmd.freq);
            div_try_r <= tbs_pkg::DIV_RESET;
            state_r   <= D_MUL;
          end else if (cmd.silence) begin
            level_r <= '0;
            done_r  <= 1'b1;
          end
        end
        D_MUL: begin
          divisor_r <= {{(tbs_pkg::DIVISOR_W - tbs_pkg::DIV_W){1'b0}}, div_try_r} *
                       {{(tbs_pkg::DIVISOR_W - tbs_pkg::FREQ_W){1'b0}}, freq_r};
          quot_r    <= clk_hz_r;
          rem_r     <= '0;
          step_r    <= '0;
          state_r   <= D_DIV;
        end
        D_DIV: begin
          quot_r <= quot_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (too_big && (div_try_r < tbs_pkg::DIV_MAX)) begin
            div_try_r <= div_try_r + 1'b1;
            state_r   <= D_MUL;
          end else begin
            divider_r <= div_try_r;
            wrap_r    <= wrap_nxt;
            level_r   <= wrap_nxt[tbs_pkg::WRAP_W-1:1];
            done_r    <= 1'b1;
            state_r   <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign status.busy    = (state_r != D_IDLE);
  assign status.done    = done_r;
  assign status.divider = divider_r;
  assign status.wrap    = wrap_r;
  assign status.level   = level_r;

endmodule

>>> hdl/tbs_ctrl.sv
// ----------------------------------------------------------------------------
// tbs_ctrl
// Sequencer controller: takes ticks and commands, keeps the sound mode,
// loop enables, beep phase and millisecond timer, asks the datapath for tone
// changes and holds the result register.
// ----------------------------------------------------------------------------
module tbs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  tbs_in_if.sink                in_if,
  tbs_out_if.source             out_if,
  output tbs_pkg::tbs_cmd_t     cmd,
  input  tbs_pkg::tbs_status_t  status
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_TONE,
    C_OUT
  } cstate_t;

  // Timer loads in milliseconds.
  localparam logic [tbs_pkg::MS_W-1:0] MS_START      = 10'd250;
  localparam logic [tbs_pkg::MS_W-1:0] MS_GAMEOVER   = 10'd700;
  localparam logic [tbs_pkg::MS_W-1:0] MS_GP_BEEP    = 10'd90;
  localparam logic [tbs_pkg::MS_W-1:0] MS_GP_FIRST   = 10'd120;
  localparam logic [tbs_pkg::MS_W-1:0] MS_MENU_ON    = 10'd180;
  localparam logic [tbs_pkg::MS_W-1:0] MS_MENU_OFF   = 10'd500;
  localparam logic [tbs_pkg::MS_W-1:0] MS_MENU_FIRST = 10'd250;

  cstate_t                      state_r;
  tbs_pkg::tbs_cmd_t            cmd_r;
  logic [2:0]                   mode_r, mode_nxt;
  logic                         gp_on_r, gp_on_nxt;
  logic                         menu_on_r, menu_on_nxt;
  logic                         phase_r, phase_nxt;
  logic [tbs_pkg::MS_W-1:0]     ms_r, ms_nxt;
  logic [tbs_pkg::MS_W-1:0]     ms_dec;
  logic                         set_tone_nxt;
  logic                         silence_nxt;
  tbs_pkg::freq_sel_t           freq_nxt;
  logic                         accept;
  logic                         out_valid_r;
  logic                         out_free;
  logic                         out_load;
  logic [2:0]                   out_mode_r;
  logic                         out_tone_on_r;
  logic [tbs_pkg::DIV_W-1:0]    out_div_r;
  logic [tbs_pkg::WRAP_W-1:0]   out_wrap_r;
  logic [tbs_pkg::LEVEL_W-1:0]  out_level_r;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = (state_r == C_OUT) && out_free;

  // Next sequencer state for the item on the input channel.
  always_comb begin
    mode_nxt     = mode_r;
    gp_on_nxt    = gp_on_r;
    menu_on_nxt  = menu_on_r;
    phase_nxt    = phase_r;
    ms_nxt       = ms_r;
    set_tone_nxt = 1'b0;
    silence_nxt  = 1'b0;
    freq_nxt     = tbs_pkg::FQ_440;
    ms_dec       = (ms_r != '0) ? (ms_r - 1'b1) : ms_r;
    case (in_if.op)
      tbs_pkg::OP_TICK: begin
        if (((mode_r == tbs_pkg::MODE_MENU) && !menu_on_r) ||
            ((mode_r == tbs_pkg::MODE_GAMEPLAY) && !gp_on_r)) begin
          // The loop of the current beep mode has been switched off.
          mode_nxt    = tbs_pkg::MODE_IDLE;
          phase_nxt   = 1'b0;
          silence_nxt = 1'b1;
        end else if ((mode_r != tbs_pkg::MODE_IDLE) &&
                     (mode_r <= tbs_pkg::MODE_GAMEOVER)) begin
          ms_nxt = ms_dec;
          if (ms_dec == '0) begin
            case (mode_r)
              tbs_pkg::MODE_START, tbs_pkg::MODE_GAMEOVER: begin
                // One-shot over: fall back to whichever loop is enabled.
                if (gp_on_r) begin
                  mode_nxt     = tbs_pkg::MODE_GAMEPLAY;
                  phase_nxt    = 1'b1;
                  set_tone_nxt = 1'b1;
                  freq_nxt     = tbs_pkg::FQ_440;
                  ms_nxt       = MS_GP_FIRST;
                end else if (menu_on_r) begin
                  mode_nxt     = tbs_pkg::MODE_MENU;
                  phase_nxt    = 1'b1;
                  set_tone_nxt = 1'b1;
                  freq_nxt     = tbs_pkg::FQ_220;
                  ms_nxt       = MS_MENU_FIRST;
                end else begin
                  mode_nxt    = tbs_pkg::MODE_IDLE;
                  silence_nxt = 1'b1;
                end
              end
              tbs_pkg::MODE_MENU: begin
                if (phase_r) begin
                  silence_nxt = 1'b1;
                  phase_nxt   = 1'b0;
                  ms_nxt      = MS_MENU_OFF;
                end else begin
                  set_tone_nxt = 1'b1;
                  freq_nxt     = tbs_pkg::FQ_220;
                  phase_nxt    = 1'b1;
                  ms_nxt       = MS_MENU_ON;
                end
              end
              default: begin
                // Gameplay beeping: equal on and off phases.
                if (phase_r) begin
                  silence_nxt = 1'b1;
                  phase_nxt   = 1'b0;
                end else begin
                  set_tone_nxt = 1'b1;
                  freq_nxt     = tbs_pkg::FQ_440;
                  phase_nxt    = 1'b1;
                end
                ms_nxt = MS_GP_BEEP;
              end
            endcase
          end
        end
      end
      tbs_pkg::OP_START: begin
        menu_on_nxt  = 1'b0;
        mode_nxt     = tbs_pkg::MODE_START;
        set_tone_nxt = 1'b1;
        freq_nxt     = tbs_pkg::FQ_880;
        ms_nxt       = MS_START;
      end
      tbs_pkg::OP_GAMEPLAY: begin
        gp_on_nxt = in_if.active;
        if (in_if.active) begin
          menu_on_nxt  = 1'b0;
          mode_nxt     = tbs_pkg::MODE_GAMEPLAY;
          phase_nxt    = 1'b1;
          set_tone_nxt = 1'b1;
          freq_nxt     = tbs_pkg::FQ_440;
          ms_nxt       = MS_GP_BEEP;
        end else if (mode_r == tbs_pkg::MODE_GAMEPLAY) begin
          mode_nxt    = tbs_pkg::MODE_IDLE;
          phase_nxt   = 1'b0;
          silence_nxt = 1'b1;
        end
      end
      tbs_pkg::OP_MENU: begin
        menu_on_nxt = in_if.active;
        if (in_if.active) begin
          gp_on_nxt    = 1'b0;
          mode_nxt     = tbs_pkg::MODE_MENU;
          phase_nxt    = 1'b1;
          set_tone_nxt = 1'b1;
          freq_nxt     = tbs_pkg::FQ_220;
          ms_nxt       = MS_MENU_ON;
        end else if (mode_r == tbs_pkg::MODE_MENU) begin
          mode_nxt    = tbs_pkg::MODE_IDLE;
          phase_nxt   = 1'b0;
          silence_nxt = 1'b1;
        end
      end
      tbs_pkg::OP_GAMEOVER: begin
        gp_on_nxt    = 1'b0;
        menu_on_nxt  = 1'b0;
        mode_nxt     = tbs_pkg::MODE_GAMEOVER;
        set_tone_nxt = 1'b1;
        freq_nxt     = tbs_pkg::FQ_180;
        ms_nxt       = MS_GAMEOVER;
      end
      tbs_pkg::OP_STOP: begin
        gp_on_nxt   = 1'b0;
        menu_on_nxt = 1'b0;
        mode_nxt    = tbs_pkg::MODE_IDLE;
        phase_nxt   = 1'b0;
        silence_nxt = 1'b1;
      end
      default: begin
        // Unused codes leave the state alone and still give a result.
      end
    endcase
  end

  // Controller state, sequencer state, datapath command and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      cmd_r       <= '0;
      mode_r      <= tbs_pkg::MODE_IDLE;
      gp_on_r     <= 1'b0;
      menu_on_r   <= 1'b0;
      phase_r     <= 1'b0;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Tone requests are single-cycle pulses, registered from the input transfer.
      cmd_r.set_tone <= accept && set_tone_nxt;
      cmd_r.silence  <= accept && silence_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        C_IDLE: begin
          if (accept) begin
            mode_r         <= mode_nxt;
            gp_on_r        <= gp_on_nxt;
            menu_on_r      <= menu_on_nxt;
            phase_r        <= phase_nxt;
            ms_r           <= ms_nxt;
            cmd_r.freq     <= freq_nxt;
            state_r        <= (set_tone_nxt || silence_nxt) ? C_TONE : C_OUT;
          end
        end
        C_TONE: begin
          if (status.done) begin
            state_r <= C_OUT;
          end
        end
        C_OUT: begin
          // Load the result once the previous one has been transferred.
          if (out_free) begin
            out_mode_r    <= mode_r;
            out_tone_on_r <= phase_r && ((mode_r == tbs_pkg::MODE_MENU) ||
                                         (mode_r == tbs_pkg::MODE_GAMEPLAY));
            out_div_r     <= status.divider;
            out_wrap_r    <= status.wrap;
            out_level_r   <= status.level;
            state_r       <= C_IDLE;
          end
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign cmd                  = cmd_r;
  assign in_if.ready          = (state_r == C_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.play_mode     = out_mode_r;
  assign out_if.tone_on       = out_tone_on_r;
  assign out_if.clock_divider = out_div_r;
  assign out_if.pwm_wrap      = out_wrap_r;
  assign out_if.pwm_level     = out_level_r;

endmodule

>>> hdl/tone_beep_sequencer.sv
// ----------------------------------------------------------------------------
// tone_beep_sequencer
// Beep and jingle sequencer that drives the settings of one PWM tone. Every
// transfer on the input channel is a millisecond tick or a command (start
// jingle, gameplay beeping, menu beeping, game over, stop), and each gives
// exactly one result with the sound mode, the beep phase and the PWM clock
// divider, wrap and level. An item that changes no tone goes straight to
// the result register; one that silences or sets a tone first waits for the
// datapath to report done. A tone search looks for the smallest divider,
// trying dividers from 1 upwards; each try is a multiply, 28 steps of the
// bit-serial divider and a check. For the 180 Hz game-over tone from a
// 125 MHz source the search ends at divider 11. The next input item is
// taken once the result is in the output register, even if that result has
// not yet been transferred. The source clock frequency is written on
// cfg_wr_en; the user must write it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module tone_beep_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tbs_pkg::CLK_W-1:0]  cfg_wr_data,
  tbs_in_if.sink                     in_if,
  tbs_out_if.source                  out_if
);

  tbs_pkg::tbs_cmd_t     cmd;
  tbs_pkg::tbs_status_t  status;

  // Sequencer controller and result register.
  tbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cmd    (cmd),
    .status (status)
  );

  // Tone set-up datapath.
  tbs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status)
  );

  // No input transfer while the divider search is still running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !status.busy)
    else $error("input transfer while the tone datapath is busy");

  // A finished tone set-up leaves a wrap within the clamp range.
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> (status.wrap >= tbs_pkg::WRAP_MIN))
    else $error("tone wrap below its minimum");

  // The compare level never exceeds half the wrap.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.level <= status.wrap[tbs_pkg::WRAP_W-1:1])
    else $error("PWM level above half the wrap");

  // The divider in use is never zero.
  a_divider_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    status.divider != '0)
    else $error("PWM clock divider is zero");

endmodule

>>> verif/tone_beep_sequencer_tb.sv
// ----------------------------------------------------------------------------
// tone_beep_sequencer_tb
// Self-checking bench for the tone beep sequencer. A queue of ticks and
// commands feeds a driver; every transfer on the command channel is also run
// through a behavioural model of the sequencer, and each status transfer is
// checked against the oldest predicted status. The source clock register is
// rewritten between phases, with the ends of its range among the settings.
// ----------------------------------------------------------------------------
module tone_beep_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  // Spare operation codes, which the sequencer must ignore.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Tone frequencies in hertz.
  localparam int unsigned HZ_JINGLE   = 880;
  localparam int unsigned HZ_GAMEPLAY = 440;
  localparam int unsigned HZ_MENU     = 220;
  localparam int unsigned HZ_GAMEOVER = 180;

  // Timer loads in milliseconds.
  localparam logic [MS_W-1:0] MS_JINGLE      = 10'd250;
  localparam logic [MS_W-1:0] MS_GAMEOVER    = 10'd700;
  localparam logic [MS_W-1:0] MS_PLAY_BEEP   = 10'd90;
  localparam logic [MS_W-1:0] MS_MENU_ON     = 10'd180;
  localparam logic [MS_W-1:0] MS_MENU_OFF    = 10'd500;
  localparam logic [MS_W-1:0] MS_PLAY_RESUME = 10'd120;
  localparam logic [MS_W-1:0] MS_MENU_RESUME = 10'd250;

  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned QUIET_LIMIT   = 40000;
  localparam int unsigned SETTLE_CYCLES = 1000;

  typedef struct packed {
    logic [2:0] op;
    logic       active;
  } seq_cmd_t;

  typedef struct packed {
    logic [2:0]         play_mode;
    logic               tone_on;
    logic [DIV_W-1:0]   divider;
    logic [WRAP_W-1:0]  wrap;
    logic [LEVEL_W-1:0] level;
  } tone_status_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CLK_W-1:0]  cfg_wr_data;

  tbs_in_if  cmd_bus ();
  tbs_out_if status_bus ();

  tone_beep_sequencer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (cmd_bus),
    .out_if      (status_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wire cmd_xfer    = cmd_bus.valid & cmd_bus.ready;
  wire status_xfer = status_bus.valid & status_bus.ready;

  // Bench bookkeeping.
  seq_cmd_t     pending[$];
  tone_status_t status_due[$];
  int unsigned  items_queued = 0;
  int unsigned  results_done = 0;
  int unsigned  mismatches   = 0;
  int unsigned  calm_left    = 0;
  int unsigned  send_gap     = 0;
  int unsigned  hold_left    = 0;
  int unsigned  long_holds   = 0;
  bit           cmd_taken    = 1'b0;

  // Behavioural copy of the sequencer state.
  logic [31:0]       m_clk_hz  = 32'(CLK_HZ_RESET);
  logic [2:0]        m_mode    = MODE_IDLE;
  logic              m_play_en = 1'b0;
  logic              m_menu_en = 1'b0;
  logic              m_phase   = 1'b0;
  logic [MS_W-1:0]   m_ms_left = '0;
  logic [DIV_W-1:0]  m_div     = DIV_RESET;
  logic [WRAP_W-1:0] m_wrap    = WRAP_RESET;
  logic [WRAP_W-1:0] m_level   = '0;

  // Smallest divider that brings the wrap into 16 bits, then clamp the wrap.
  // A zero quotient wraps round to a huge value and so drives the divider up.
  function automatic void load_tone(input int unsigned freq);
    logic [31:0] d;
    logic [31:0] w;
    d = 32'd1;
    w = m_clk_hz / freq - 32'd1;
    while (w > 32'(WRAP_MAX) && d < 32'(DIV_MAX)) begin
      d = d + 32'd1;
      w = m_clk_hz / (d * freq) - 32'd1;
    end
    if (w > 32'(WRAP_MAX)) w = 32'(WRAP_MAX);
    if (w < 32'(WRAP_MIN)) w = 32'(WRAP_MIN);
    m_div   = d[DIV_W-1:0];
    m_wrap  = w[WRAP_W-1:0];
    m_level = w[WRAP_W:1];
  endfunction

  function automatic void go_quiet();
    m_mode  = MODE_IDLE;
    m_phase = 1'b0;
    m_level = '0;
  endfunction

  function automatic void beep_on(input logic [2:0] mode, input int unsigned freq,
                                  input logic [MS_W-1:0] ms);
    m_mode  = mode;
    m_phase = 1'b1;
    load_tone(freq);
    m_ms_left = ms;
  endfunction

  // One millisecond of the sound timers.
  function automatic void on_tick();
    if (m_mode == MODE_IDLE || m_mode > MODE_GAMEOVER) return;
    if ((m_mode == MODE_MENU && !m_menu_en) || (m_mode == MODE_GAMEPLAY && !m_play_en)) begin
      go_quiet();
      return;
    end
    if (m_ms_left != '0) m_ms_left = m_ms_left - 1'b1;
    if (m_ms_left != '0) return;
    case (m_mode)
      MODE_START, MODE_GAMEOVER: begin
        if (m_play_en) begin
          beep_on(MODE_GAMEPLAY, HZ_GAMEPLAY, MS_PLAY_RESUME);
        end else if (m_menu_en) begin
          beep_on(MODE_MENU, HZ_MENU, MS_MENU_RESUME);
        end else begin
          m_mode  = MODE_IDLE;
          m_level = '0;
        end
      end
      MODE_MENU: begin
        if (m_phase) begin
          m_level   = '0;
          m_phase   = 1'b0;
          m_ms_left = MS_MENU_OFF;
        end else begin
          beep_on(MODE_MENU, HZ_MENU, MS_MENU_ON);
        end
      end
      default: begin
        if (m_phase) begin
          m_level   = '0;
          m_phase   = 1'b0;
          m_ms_left = MS_PLAY_BEEP;
        end else begin
          beep_on(MODE_GAMEPLAY, HZ_GAMEPLAY, MS_PLAY_BEEP);
        end
      end
    endcase
  endfunction

  // Apply one tick or command and return the status it should report.
  function automatic tone_status_t advance_sequencer(input logic [2:0] op, input logic act);
    tone_status_t st;
    case (op)
      OP_TICK: begin
        on_tick();
      end
      OP_START: begin
        m_menu_en = 1'b0;
        m_mode    = MODE_START;
        load_tone(HZ_JINGLE);
        m_ms_left = MS_JINGLE;
      end
      OP_GAMEPLAY: begin
        m_play_en = act;
        if (act) begin
          m_menu_en = 1'b0;
          beep_on(MODE_GAMEPLAY, HZ_GAMEPLAY, MS_PLAY_BEEP);
        end else if (m_mode == MODE_GAMEPLAY) begin
          go_quiet();
        end
      end
      OP_MENU: begin
        m_menu_en = act;
        if (act) begin
          m_play_en = 1'b0;
          beep_on(MODE_MENU, HZ_MENU, MS_MENU_ON);
        end else if (m_mode == MODE_MENU) begin
          go_quiet();
        end
      end
      OP_GAMEOVER: begin
        m_play_en = 1'b0;
        m_menu_en = 1'b0;
        m_mode    = MODE_GAMEOVER;
        load_tone(HZ_GAMEOVER);
        m_ms_left = MS_GAMEOVER;
      end
      OP_STOP: begin
        m_play_en = 1'b0;
        m_menu_en = 1'b0;
        go_quiet();
      end
      default: begin
      end
    endcase
    st.play_mode = m_mode;
    st.tone_on   = m_phase && (m_mode == MODE_MENU || m_mode == MODE_GAMEPLAY);
    st.divider   = m_div;
    st.wrap      = m_wrap;
    st.level     = m_level[LEVEL_W-1:0];
    return st;
  endfunction

  // Length of an idle stretch: none during a calm spell, else mostly short.
  function automatic int unsigned idle_len(input int unsigned pct);
    int unsigned r;
    if (calm_left != 0) return 0;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    if (r < pct * 9 / 10) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Calm spells, in which neither side idles, start now and then.
  always @(posedge clk) begin
    if (calm_left != 0) calm_left--;
    else if ($urandom_range(0, 999) < 3) calm_left = $urandom_range(100, 400);
  end

  // Command driver: a new item or an idle gap follows at the falling edge after a transfer.
  always @(negedge clk) begin : cmd_driver
    seq_cmd_t nxt;
    if (rst_n && (!cmd_bus.valid || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (send_gap != 0) begin
        cmd_bus.valid <= 1'b0;
        send_gap--;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        cmd_bus.valid  <= 1'b1;
        cmd_bus.op     <= nxt.op;
        cmd_bus.active <= nxt.active;
        send_gap = idle_len(45);
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Status sink: random stalls, and a long hold while commands are backed up.
  always @(negedge clk) begin
    if (!rst_n) begin
      status_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      status_bus.ready <= 1'b0;
      hold_left--;
    end else if (long_holds < 2 && pending.size() >= 15 && cmd_bus.valid) begin
      status_bus.ready <= 1'b0;
      hold_left = LONG_HOLD - 1;
      long_holds++;
    end else begin
      hold_left = idle_len(20);
      if (hold_left != 0) begin
        status_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        status_bus.ready <= 1'b1;
      end
    end
  end

  // Predict on every command transfer and check every status transfer.
  always @(posedge clk) begin : scoreboard
    tone_status_t seen;
    tone_status_t want;
    if (rst_n && cmd_xfer) begin
      status_due.push_back(advance_sequencer(cmd_bus.op, cmd_bus.active));
      cmd_taken = 1'b1;
    end
    if (rst_n && status_xfer) begin
      seen = '{play_mode: status_bus.play_mode, tone_on: status_bus.tone_on,
               divider: status_bus.clock_divider, wrap: status_bus.pwm_wrap,
               level: status_bus.pwm_level};
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected status: mode %0d tone %0b div %0d wrap %0d level %0d",
                   $realtime, seen.play_mode, seen.tone_on, seen.divider, seen.wrap,
                   seen.level);
      end else begin
        want = status_due.pop_front();
        results_done++;
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected mode %0d tone %0b div %0d wrap %0d level %0d",
                     $realtime, want.play_mode, want.tone_on, want.divider, want.wrap,
                     want.level);
            $display("%0t: got      mode %0d tone %0b div %0d wrap %0d level %0d",
                     $realtime, seen.play_mode, seen.tone_on, seen.divider, seen.wrap,
                     seen.level);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing is transferred for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (cmd_xfer || status_xfer) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic queue_item(input logic [2:0] op, input logic act);
    pending.push_back('{op: op, active: act});
    items_queued++;
  endtask

  task automatic queue_ticks(input int unsigned n);
    repeat (n) queue_item(OP_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Mostly commands followed by short runs of ticks, with a little noise in
  // between.
  task automatic queue_random(input int unsigned n_cmds);
    int unsigned pick;
    int unsigned run;
    repeat (n_cmds) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) queue_item(OP_START, 1'($urandom_range(0, 1)));
      else if (pick < 35) queue_item(OP_GAMEPLAY, 1'b1);
      else if (pick < 55) queue_item(OP_MENU, 1'b1);
      else if (pick < 67) queue_item(OP_GAMEOVER, 1'($urandom_range(0, 1)));
      else if (pick < 75) queue_item(OP_GAMEPLAY, 1'b0);
      else if (pick < 83) queue_item(OP_MENU, 1'b0);
      else if (pick < 93) queue_item(OP_STOP, 1'($urandom_range(0, 1)));
      else if (pick < 96)
        queue_item(($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO,
                   1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 60) run = $urandom_range(0, 2);
      else run = $urandom_range(3, 8);
      queue_ticks(run);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (results_done != items_queued);
  endtask

  // Wait until the sequencer is idle, rewrite the source clock, then start
  // a phase with every tone followed by random traffic.
  task automatic clock_phase(input logic [CLK_W-1:0] hz, input int unsigned n_cmds);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    m_clk_hz = 32'(hz);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    queue_item(OP_START, 1'b0);
    queue_ticks(1);
    queue_item(OP_GAMEOVER, 1'b1);
    queue_ticks(1);
    queue_item(OP_GAMEPLAY, 1'b1);
    queue_ticks(1);
    queue_item(OP_MENU, 1'b1);
    queue_ticks(1);
    queue_random(n_cmds);
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cmd_bus.valid  = 1'b0;
    cmd_bus.op     = OP_TICK;
    cmd_bus.active = 1'b0;
    status_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset clock: idle behaviour, spare codes, every
    // command and the enable clears in and out of their own modes.
    queue_item(OP_TICK, 1'b0);
    queue_item(OP_SPARE_LO, 1'b1);
    queue_item(OP_SPARE_HI, 1'b0);
    queue_item(OP_STOP, 1'b0);
    queue_item(OP_MENU, 1'b0);
    queue_item(OP_GAMEPLAY, 1'b0);
    queue_item(OP_START, 1'b1);
    queue_item(OP_TICK, 1'b1);
    queue_item(OP_GAMEPLAY, 1'b0);
    queue_item(OP_MENU, 1'b1);
    queue_item(OP_TICK, 1'b0);
    queue_item(OP_GAMEPLAY, 1'b1);
    queue_item(OP_TICK, 1'b1);
    queue_item(OP_MENU, 1'b0);
    queue_item(OP_GAMEPLAY, 1'b0);
    queue_item(OP_GAMEOVER, 1'b0);
    queue_item(OP_TICK, 1'b0);
    queue_item(OP_STOP, 1'b1);
    queue_item(OP_MENU, 1'b1);
    queue_item(OP_MENU, 1'b0);
    queue_item(OP_TICK, 1'b1);
    queue_random(4);

    // Range ends, the all-ones field, a clock slower than every tone, one just
    // above every tone that hits the lower wrap clamp, and a random setting.
    clock_phase(28'd1000000, 1);
    clock_phase(28'd200000000, 1);
    clock_phase(28'hFFFFFFF, 0);
    clock_phase(28'd100, 0);
    clock_phase(28'd1000, 1);
    clock_phase(CLK_W'($urandom_range(1000000, 200000000)), 0);
    clock_phase(CLK_HZ_RESET, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
